FILE: rtl/mcpq_pkg.sv
// Shared types and constants for the median cut palette quantiser.
// Used by mcpq_ctrl, mcpq_datapath and the top level; no dependencies.
package mcpq_pkg;

    // palette depth and channel width follow from the fixed field widths
    localparam int MAX_COLORS   = 256;
    localparam int CHANNEL_BITS = 5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] MODE_256     = 2'd0;
    localparam logic [1:0] MODE_16      = 2'd1;
    localparam logic [1:0] MODE_4       = 2'd2;
    localparam logic [1:0] MODE_4_ALIAS = 2'd3;

    localparam int LOG_T256 = 8;
    localparam int LOG_T16  = 4;
    localparam int LOG_T4   = 2;

    typedef enum logic [2:0] {
        SCAN_INIT   = 3'd0,
        SCAN_SPREAD = 3'd1,
        SCAN_SUM    = 3'd2,
        SCAN_BUCKET = 3'd3,
        SCAN_COPY   = 3'd4,
        SCAN_LEAF   = 3'd5,
        SCAN_RANK   = 3'd6
    } scan_op_t;

    typedef struct packed {
        logic       load;
        logic       reduce_init;
        logic       close;
        logic       pop;
        logic       scan_start;
        scan_op_t   op;
        logic       key_clr;
        logic       key_inc;
        logic       pick_ch;
        logic       push_halves;
        logic       div_start;
        logic [1:0] div_ch;
        logic       rank_clr;
        logic       rank_step;
        logic       rd_start;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic stack_empty;
        logic is_leaf;
        logic identity;
        logic key_last;
        logic div_busy;
        logic rank_more;
        logic read_ok;
        logic out_valid;
    } dp_stat_t;

endpackage

FILE: rtl/mcpq_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit Q_W bits.
// Used by mcpq_datapath for the per-channel leaf means; no dependencies.
module mcpq_div #(
    parameter int NUM_W = 15,
    parameter int DEN_W = 9,
    parameter int Q_W   = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (Q_W - 1);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_reg - dsh_reg : rem_reg;
            q_next   = Q_W'({q_reg, fits});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/mcpq_datapath.sv
// Datapath: palette memories, scan pipeline, split stack, mean divider, output register.
// Depends on mcpq_pkg and mcpq_div; driven by mcpq_ctrl commands.
module mcpq_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mcpq_pkg::dp_cmd_t  cmd,
    output mcpq_pkg::dp_stat_t stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_data,
    input  logic [14:0]        in_color,
    input  logic [7:0]         in_idx,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         out_index,
    output logic [14:0]        out_color,
    output logic [8:0]         out_size
);

    localparam int MAX_COLORS   = mcpq_pkg::MAX_COLORS;
    localparam int CHANNEL_BITS = mcpq_pkg::CHANNEL_BITS;
    localparam int CW   = $clog2(MAX_COLORS);
    localparam int NW   = CW + 1;
    localparam int CB   = CHANNEL_BITS;
    localparam int COLW = 3 * CB;
    localparam int SW   = NW + CB;
    localparam int SDW  = $clog2(CW + 3);
    localparam int SD   = 1 << SDW;
    localparam logic [CB-1:0] CH_MAX = '1;
    localparam logic [NW-1:0] MAX_N  = NW'(MAX_COLORS);

    // configuration and palette control
    logic [1:0]    mode_reg;
    logic [NW-1:0] count_reg;
    logic          closed_reg;
    logic          identity_reg;
    logic [NW-1:0] limit_reg;
    logic [NW-1:0] red_cnt_reg;

    // memories
    logic [COLW-1:0] color_mem   [MAX_COLORS];
    logic [CW-1:0]   order_mem   [MAX_COLORS];
    logic [CW-1:0]   tmp_mem     [MAX_COLORS];
    logic [COLW-1:0] leaf_mem    [MAX_COLORS];
    logic [CW-1:0]   map_mem     [MAX_COLORS];
    logic [COLW-1:0] reduced_mem [MAX_COLORS];

    // split stack
    logic [CW-1:0] st_lo [SD];
    logic [NW-1:0] st_n  [SD];
    logic [SDW:0]  sp_reg;
    logic [SDW-1:0] top_idx;
    logic [CW-1:0] lo_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] half;

    // scan pipeline
    mcpq_pkg::scan_op_t sc_op_reg;
    logic          sc_busy_reg;
    logic [NW-1:0] sc_idx_reg;
    logic [NW-1:0] sc_end_reg;
    logic          issue_v;
    logic          p1_v_reg, p2_v_reg;
    logic [CW-1:0] sc_addr;
    logic [CW-1:0] ord_q, tmp_q, map_q;
    logic [COLW-1:0] leaf_q, color_q, red_q;
    logic [CW-1:0] p1_idx_reg, p2_idx_reg, p2_ord_reg, p2_tmp_reg;
    logic [COLW-1:0] p2_leaf_reg;
    logic [NW-1:0] sc_start_idx, sc_end_idx;
    logic          whole;

    // per-scan accumulators
    logic [CB-1:0] ch_val [3];
    logic [CB-1:0] mn_reg [3];
    logic [CB-1:0] mx_reg [3];
    logic [SW-1:0] sum_reg [3];
    logic [CB-1:0] avg_reg [3];
    logic [COLW-1:0] avg_col;
    logic [1:0]    ch_sel_reg;
    logic [CB-1:0] key_reg;
    logic [CW-1:0] wr_ptr_reg;
    logic          key_hit;
    logic [CB-1:0] rr, gg, bb;
    logic [1:0]    pick;

    // ranking
    logic [NW-1:0]   rank_reg;
    logic            has_cur_reg;
    logic [COLW-1:0] cur_reg;
    logic            cand_v_reg;
    logic [COLW-1:0] cand_reg;
    logic            rank_hit;
    logic            cand_better;

    // divider
    logic [1:0]    div_ch_reg;
    logic          div_busy, div_done;
    logic [CB-1:0] div_quo;

    // read path
    logic [7:0]    rd_idx_reg;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] col_raddr;
    logic          out_valid_reg;
    logic [7:0]    out_index_reg;
    logic [14:0]   out_color_reg;
    logic [8:0]    out_size_reg;

    // load and reduce set-up
    logic [NW-1:0]   eff_cnt;
    logic            load_wr;
    logic [COLW-1:0] color_in;
    int              tlog;
    int              tgt;
    logic            identity_next;
    logic [NW-1:0]   limit_next;

    assign color_in = COLW'(in_color);
    assign eff_cnt  = closed_reg ? '0 : count_reg;
    assign load_wr  = cmd.load && (eff_cnt < MAX_N);

    always_comb
    begin
        unique case (mode_reg)
            mcpq_pkg::MODE_256: tlog = mcpq_pkg::LOG_T256;
            mcpq_pkg::MODE_16:  tlog = mcpq_pkg::LOG_T16;
            default:            tlog = mcpq_pkg::LOG_T4;
        endcase
        tgt           = 1 << tlog;
        identity_next = (int'(count_reg) <= tgt);
        limit_next    = NW'((int'(count_reg) + tgt - 1) >> tlog);
    end

    assign top_idx = SDW'(sp_reg - 1'b1);
    assign half    = n_reg >> 1;

    assign whole        = (cmd.op == mcpq_pkg::SCAN_INIT) || (cmd.op == mcpq_pkg::SCAN_RANK);
    assign sc_start_idx = whole ? '0 : NW'(lo_reg);
    assign sc_end_idx   = whole ? count_reg : NW'(lo_reg) + n_reg;
    assign issue_v      = sc_busy_reg && (sc_idx_reg < sc_end_reg);
    assign sc_addr      = CW'(sc_idx_reg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ch_val[c] = color_q[(2 - c) * CB +: CB];
        end
    end

    assign key_hit     = (ch_val[ch_sel_reg] == key_reg);
    assign avg_col     = {avg_reg[0], avg_reg[1], avg_reg[2]};
    assign rank_hit    = has_cur_reg && (p2_leaf_reg == cur_reg);
    assign cand_better = (!has_cur_reg || (p2_leaf_reg > cur_reg))
                         && (!cand_v_reg || (p2_leaf_reg < cand_reg));

    assign rr = mx_reg[0] - mn_reg[0];
    assign gg = mx_reg[1] - mn_reg[1];
    assign bb = mx_reg[2] - mn_reg[2];

    // widest spread wins, R before G before B on ties
    always_comb
    begin
        priority if (rr >= gg && rr >= bb)
            pick = 2'd0;
        else if (gg >= bb)
            pick = 2'd1;
        else
            pick = 2'd2;
    end

    assign rd_addr   = CW'(rd_idx_reg);
    assign col_raddr = p1_v_reg ? ord_q : rd_addr;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mcpq_pkg::MODE_256;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            sp_reg      <= '0;
            sc_busy_reg <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            has_cur_reg <= 1'b0;
            cand_v_reg  <= 1'b0;
            rank_reg    <= '0;
            red_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= (cfg_data == mcpq_pkg::MODE_4_ALIAS) ? mcpq_pkg::MODE_4 : cfg_data;
            end
            if (cmd.load)
            begin
                closed_reg <= 1'b0;
                count_reg  <= load_wr ? eff_cnt + 1'b1 : eff_cnt;
            end
            if (cmd.close)
            begin
                closed_reg <= 1'b1;
            end
            if (cmd.reduce_init)
            begin
                sp_reg      <= (SDW + 1)'(1);
                red_cnt_reg <= count_reg;
            end
            else if (cmd.push_halves)
            begin
                sp_reg <= sp_reg + (SDW + 1)'(2);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_reg - 1'b1;
            end

            if (cmd.scan_start)
            begin
                sc_busy_reg <= 1'b1;
            end
            else
            begin
                sc_busy_reg <= issue_v || p1_v_reg || p2_v_reg;
            end
            p1_v_reg <= issue_v;
            p2_v_reg <= p1_v_reg;

            if (cmd.rank_clr)
            begin
                rank_reg    <= '0;
                has_cur_reg <= 1'b0;
                cand_v_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.rank_step)
                begin
                    if (has_cur_reg)
                    begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                    red_cnt_reg <= has_cur_reg ? rank_reg + 1'b1 : rank_reg;
                    if (cand_v_reg)
                    begin
                        has_cur_reg <= 1'b1;
                    end
                end
                if (cmd.scan_start)
                begin
                    cand_v_reg <= 1'b0;
                end
                else if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_RANK && cand_better)
                begin
                    cand_v_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.reduce_init)
        begin
            identity_reg <= identity_next;
            limit_reg    <= limit_next;
            st_lo[0]     <= '0;
            st_n[0]      <= count_reg;
        end
        if (cmd.push_halves)
        begin
            st_lo[SDW'(sp_reg)]        <= CW'(NW'(lo_reg) + half);
            st_n[SDW'(sp_reg)]         <= n_reg - half;
            st_lo[SDW'(sp_reg + 1'b1)] <= lo_reg;
            st_n[SDW'(sp_reg + 1'b1)]  <= half;
        end
        if (cmd.pop)
        begin
            lo_reg <= st_lo[top_idx];
            n_reg  <= st_n[top_idx];
        end

        if (cmd.scan_start)
        begin
            sc_op_reg  <= cmd.op;
            sc_idx_reg <= sc_start_idx;
            sc_end_reg <= sc_end_idx;
        end
        else if (issue_v)
        begin
            sc_idx_reg <= sc_idx_reg + 1'b1;
        end
        p1_idx_reg  <= sc_addr;
        p2_idx_reg  <= p1_idx_reg;
        p2_ord_reg  <= ord_q;
        p2_tmp_reg  <= tmp_q;
        p2_leaf_reg <= leaf_q;

        if (cmd.scan_start)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mn_reg[c]  <= CH_MAX;
                mx_reg[c]  <= '0;
                sum_reg[c] <= '0;
            end
        end
        else if (p2_v_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (sc_op_reg == mcpq_pkg::SCAN_SPREAD)
                begin
                    if (ch_val[c] < mn_reg[c])
                    begin
                        mn_reg[c] <= ch_val[c];
                    end
                    if (ch_val[c] > mx_reg[c])
                    begin
                        mx_reg[c] <= ch_val[c];
                    end
                end
                if (sc_op_reg == mcpq_pkg::SCAN_SUM)
                begin
                    sum_reg[c] <= sum_reg[c] + SW'(ch_val[c]);
                end
            end
        end

        if (cmd.pick_ch)
        begin
            ch_sel_reg <= pick;
        end
        if (cmd.key_clr)
        begin
            key_reg    <= '0;
            wr_ptr_reg <= lo_reg;
        end
        else
        begin
            if (cmd.key_inc)
            begin
                key_reg <= key_reg + 1'b1;
            end
            if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_BUCKET && key_hit)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
        end

        if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_RANK && cand_better)
        begin
            cand_reg <= p2_leaf_reg;
        end
        if (cmd.rank_step && cand_v_reg)
        begin
            cur_reg <= cand_reg;
        end

        if (cmd.div_start)
        begin
            div_ch_reg <= cmd.div_ch;
        end
        if (div_done)
        begin
            avg_reg[div_ch_reg] <= div_quo;
        end

        if (cmd.rd_start)
        begin
            rd_idx_reg <= in_idx;
        end
        if (cmd.out_load)
        begin
            out_index_reg <= identity_reg ? rd_idx_reg : 8'(map_q);
            out_color_reg <= 15'(identity_reg ? color_q : red_q);
            out_size_reg  <= 9'(red_cnt_reg);
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            color_mem[CW'(eff_cnt)] <= color_in;
        end
        color_q <= color_mem[col_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_INIT)
        begin
            order_mem[p2_idx_reg] <= p2_idx_reg;
        end
        else if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_COPY)
        begin
            order_mem[p2_idx_reg] <= p2_tmp_reg;
        end
        ord_q <= order_mem[sc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_BUCKET && key_hit)
        begin
            tmp_mem[wr_ptr_reg] <= p2_ord_reg;
        end
        tmp_q <= tmp_mem[sc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_LEAF)
        begin
            leaf_mem[p2_ord_reg] <= avg_col;
        end
        leaf_q <= leaf_mem[sc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg && sc_op_reg == mcpq_pkg::SCAN_RANK && rank_hit)
        begin
            map_mem[p2_idx_reg] <= CW'(rank_reg);
        end
        map_q <= map_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_step && has_cur_reg)
        begin
            reduced_mem[CW'(rank_reg)] <= cur_reg;
        end
        red_q <= reduced_mem[map_q];
    end

    mcpq_div #(
        .NUM_W (SW),
        .DEN_W (NW),
        .Q_W   (CB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (sum_reg[cmd.div_ch]),
        .den   (n_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        stat.scan_busy   = sc_busy_reg;
        stat.stack_empty = (sp_reg == '0);
        stat.is_leaf     = (n_reg <= limit_reg);
        stat.identity    = identity_reg;
        stat.key_last    = (key_reg == CH_MAX);
        stat.div_busy    = div_busy;
        stat.rank_more   = cand_v_reg;
        stat.read_ok     = closed_reg
                           && ({{NW{1'b0}}, rd_idx_reg} < {8'b0, count_reg});
        stat.out_valid   = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_color = out_color_reg;
    assign out_size  = out_size_reg;

endmodule

FILE: rtl/mcpq_ctrl.sv
// Controller: sequences loads, reads and the median cut passes over the datapath.
// Depends on mcpq_pkg.
module mcpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_req,
    input  logic               in_last,
    output logic               in_ready,
    input  mcpq_pkg::dp_stat_t stat,
    output mcpq_pkg::dp_cmd_t  cmd
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_INIT  = 18'h00002,
        ST_CHK   = 18'h00004,
        ST_WINIT = 18'h00008,
        ST_POP   = 18'h00010,
        ST_DEC   = 18'h00020,
        ST_WSPRD = 18'h00040,
        ST_BKT   = 18'h00080,
        ST_WBKT  = 18'h00100,
        ST_WCOPY = 18'h00200,
        ST_WSUM  = 18'h00400,
        ST_DIV   = 18'h00800,
        ST_WDIV  = 18'h01000,
        ST_WLEAF = 18'h02000,
        ST_WRANK = 18'h04000,
        ST_RDA   = 18'h08000,
        ST_RDB   = 18'h10000,
        ST_RDC   = 18'h20000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE) && !stat.out_valid;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == mcpq_pkg::REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_INIT;
                        end
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = ST_RDA;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.reduce_init = 1'b1;
                state_next      = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.identity)
                begin
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.op         = mcpq_pkg::SCAN_INIT;
                    state_next     = ST_WINIT;
                end
            end
            ST_WINIT:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (stat.stack_empty)
                begin
                    cmd.rank_clr   = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.op         = mcpq_pkg::SCAN_RANK;
                    state_next     = ST_WRANK;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                cmd.scan_start = 1'b1;
                if (stat.is_leaf)
                begin
                    cmd.op     = mcpq_pkg::SCAN_SUM;
                    state_next = ST_WSUM;
                end
                else
                begin
                    cmd.op     = mcpq_pkg::SCAN_SPREAD;
                    state_next = ST_WSPRD;
                end
            end
            ST_WSPRD:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.pick_ch = 1'b1;
                    cmd.key_clr = 1'b1;
                    state_next  = ST_BKT;
                end
            end
            // stable sort: one pass per key value, copied back afterwards
            ST_BKT:
            begin
                cmd.scan_start = 1'b1;
                cmd.op         = mcpq_pkg::SCAN_BUCKET;
                state_next     = ST_WBKT;
            end
            ST_WBKT:
            begin
                if (!stat.scan_busy)
                begin
                    if (stat.key_last)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.op         = mcpq_pkg::SCAN_COPY;
                        state_next     = ST_WCOPY;
                    end
                    else
                    begin
                        cmd.key_inc = 1'b1;
                        state_next  = ST_BKT;
                    end
                end
            end
            ST_WCOPY:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.push_halves = 1'b1;
                    state_next      = ST_POP;
                end
            end
            ST_WSUM:
            begin
                if (!stat.scan_busy)
                begin
                    ch_next    = 2'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_ch    = ch_reg;
                state_next    = ST_WDIV;
            end
            ST_WDIV:
            begin
                if (!stat.div_busy)
                begin
                    if (ch_reg == 2'd2)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.op         = mcpq_pkg::SCAN_LEAF;
                        state_next     = ST_WLEAF;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_WLEAF:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = ST_POP;
                end
            end
            // one pass per distinct leaf colour, ascending, plus one closing pass
            ST_WRANK:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.rank_step = 1'b1;
                    if (stat.rank_more)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.op         = mcpq_pkg::SCAN_RANK;
                    end
                    else
                    begin
                        cmd.close  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RDA:
            begin
                state_next = stat.read_ok ? ST_RDB : ST_IDLE;
            end
            ST_RDB:
            begin
                state_next = ST_RDC;
            end
            ST_RDC:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

FILE: rtl/median_cut_palette_quantizer.sv
// Top level of the median cut palette quantiser.
// Depends on mcpq_pkg, mcpq_ctrl, mcpq_datapath (and mcpq_div below it).
//
//  channel | signals                      | moves
//  --------+------------------------------+------------------------------------
//  s_      | tvalid tready tdata tlast tuser | palette loads and mapping reads
//  m_      | tvalid tready tdata          | mapping results, one per good read
//  cfg_    | valid ready data             | target_size_mode
//
// A read goes through the map memory, then the reduced-colour memory, to the output
// register (for an identity palette, through the colour memory). The final load holds
// s_tready low while the cut runs: each split scans its bucket 2 + 2^CHANNEL_BITS times,
// each leaf scans it twice and runs the divider once per channel, and ranking
// scans the whole palette once per distinct leaf colour plus one closing pass.
// Reset is asynchronous and clears control state only; memories start unknown.
// A beat waiting on m_ stalls further input beats until taken.
module median_cut_palette_quantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // color[14:0], entry_index[22:15], zero pad
    input  logic        s_tlast,
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // new_index[7:0], new_color[22:8], reduced_size[31:23]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    mcpq_pkg::dp_cmd_t  cmd;
    mcpq_pkg::dp_stat_t stat;
    logic [7:0]         out_index;
    logic [14:0]        out_color;
    logic [8:0]         out_size;

    assign cfg_ready = 1'b1;

    mcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcpq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_color  (s_tdata[14:0]),
        .in_idx    (s_tdata[22:15]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_index (out_index),
        .out_color (out_color),
        .out_size  (out_size)
    );

    assign m_tdata = {out_size, out_color, out_index};

endmodule
